>>> design/battery_energy_step_sim_top_assert.svh
// Assertion macros used by the battery step simulator sequencer.
`ifndef BATTERY_ENERGY_STEP_SIM_TOP_ASSERT_SVH
`define BATTERY_ENERGY_STEP_SIM_TOP_ASSERT_SVH
// Check a property on every clock edge outside reset.
`define BES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define BES_ASSERT_ALL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> design/bes_pkg.sv
// ----------------------------------------------------------------------------
// bes_pkg
// Types and constants shared by the battery step simulator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package bes_pkg;
	localparam logic [2:0] CFG_CAPACITY        = 3'd0;
	localparam logic [2:0] CFG_INITIAL_ENERGY  = 3'd1;
	localparam logic [2:0] CFG_CHARGE_SLOPE    = 3'd2;
	localparam logic [2:0] CFG_DISCHARGE_SLOPE = 3'd3;
	localparam logic [2:0] CFG_CHARGE_GAIN     = 3'd4;
	localparam logic [2:0] CFG_DISCHARGE_GAIN  = 3'd5;
	localparam logic [2:0] CFG_PV_GAIN_FIRST   = 3'd6;
	localparam logic [2:0] CFG_PV_GAIN_SECOND  = 3'd7;

	typedef struct packed {
		logic [30:0]        capacity;
		logic [30:0]        initial_energy;
		logic signed [31:0] charge_slope;
		logic signed [31:0] discharge_slope;
		logic [30:0]        charge_gain;
		logic [30:0]        discharge_gain;
		logic [30:0]        pv_gain_first;
		logic [30:0]        pv_gain_second;
	} cfg_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MUL_S0,
		CMD_MUL_S1,
		CMD_SUM,
		CMD_DIR,
		CMD_DIV,
		CMD_QUO,
		CMD_TRIAL_A,
		CMD_TRIAL_B,
		CMD_TRIAL_C,
		CMD_APPLY,
		CMD_FIN
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic last;  // final back-off trial: hold t at zero
	} ctl_t;

	typedef struct packed {
		logic trial_ok;
	} sts_t;
endpackage
`default_nettype wire

>>> design/battery_energy_step_sim_top.sv
// ----------------------------------------------------------------------------
// battery_energy_step_sim_top
// Battery energy step simulator: one battery update per accepted time step.
// ----------------------------------------------------------------------------
// Each transaction on the slave stream is one time step: load and per-roof
// solar samples in Q16.16. The block weighs the solar samples, charges on
// surplus and discharges on deficit, backs the power off until the energy
// limit holds, and returns one result transaction with the new energy level,
// the applied power, a loss flag and the running totals. A step uses 1 to
// BACKOFF_STEPS+1 back-off trials. All products go through the single
// shared multiplier: two solar products, one reciprocal product that divides
// the request by BACKOFF_STEPS, two products per trial and one for the
// applied energy. A finished result waits in the output register while the
// next step is accepted and processed. Write configuration only while no
// step is in flight.
`default_nettype none
module battery_energy_step_sim_top #(
	parameter int unsigned N_ROOFS       = 2,
	parameter int unsigned BACKOFF_STEPS = 30
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// load_sample[30:0], solar_first[61:31], solar_second[92:62], pad
	input  wire [95:0]   s_axis_tdata,
	// start_of_run
	input  wire          s_axis_tuser,
	input  wire          s_axis_tlast,   // end_of_run
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// energy_level[30:0], applied_power[62:31], loss_count[86:63],
	// deficit_total[134:87], load_total[182:135], pad
	output logic [183:0] m_axis_tdata,
	// loss_flag
	output logic         m_axis_tuser,
	output logic         m_axis_tlast,   // run_done
	input  wire          cfg_we,
	input  wire [2:0]    cfg_index,
	input  wire [31:0]   cfg_wdata
);
	import bes_pkg::*;

	cfg_t               cfg_q;
	ctl_t               ctl;
	sts_t               sts;
	logic [30:0]        energy_level;
	logic signed [31:0] applied_power;
	logic [23:0]        loss_count;
	logic [47:0]        deficit_total, load_total;

	// Configuration registers; every index of the 3-bit port names one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{capacity: '0, initial_energy: '0, charge_slope: '0,
				discharge_slope: '0, charge_gain: 31'd65536, discharge_gain: 31'd65536,
				pv_gain_first: '0, pv_gain_second: '0};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAPACITY:        cfg_q.capacity        <= cfg_wdata[30:0];
				CFG_INITIAL_ENERGY:  cfg_q.initial_energy  <= cfg_wdata[30:0];
				CFG_CHARGE_SLOPE:    cfg_q.charge_slope    <= $signed(cfg_wdata);
				CFG_DISCHARGE_SLOPE: cfg_q.discharge_slope <= $signed(cfg_wdata);
				CFG_CHARGE_GAIN:     cfg_q.charge_gain     <= cfg_wdata[30:0];
				CFG_DISCHARGE_GAIN:  cfg_q.discharge_gain  <= cfg_wdata[30:0];
				CFG_PV_GAIN_FIRST:   cfg_q.pv_gain_first   <= cfg_wdata[30:0];
				CFG_PV_GAIN_SECOND:  cfg_q.pv_gain_second  <= cfg_wdata[30:0];
				default: begin
				end
			endcase
		end
	end

	// Sequence the step and own both handshakes.
	bes_ctrl #(
		.BACKOFF_STEPS(BACKOFF_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// Hold the arithmetic, the battery state and the result register.
	bes_datapath #(
		.N_ROOFS      (N_ROOFS),
		.BACKOFF_STEPS(BACKOFF_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.ctl          (ctl),
		.sts          (sts),
		.load_sample  (s_axis_tdata[30:0]),
		.solar_first  (s_axis_tdata[61:31]),
		.solar_second (s_axis_tdata[92:62]),
		.start_of_run (s_axis_tuser),
		.end_of_run   (s_axis_tlast),
		.energy_level (energy_level),
		.applied_power(applied_power),
		.loss_flag    (m_axis_tuser),
		.loss_count   (loss_count),
		.deficit_total(deficit_total),
		.load_total   (load_total),
		.run_done     (m_axis_tlast)
	);

	// Pack the result fields, lowest field first.
	assign m_axis_tdata = {1'b0, load_total, deficit_total, loss_count,
		applied_power, energy_level};
endmodule
`default_nettype wire

>>> design/bes_datapath.sv
// ----------------------------------------------------------------------------
// bes_datapath
// Shared multiplier, reciprocal divide by the step count, back-off trial and
// accumulators of the battery step simulator.
// ----------------------------------------------------------------------------
`default_nettype none
module bes_datapath #(
	parameter int unsigned N_ROOFS       = 2,
	parameter int unsigned BACKOFF_STEPS = 30
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire bes_pkg::cfg_t  cfg,
	input  wire bes_pkg::ctl_t  ctl,
	output bes_pkg::sts_t       sts,
	input  wire [30:0]          load_sample,
	input  wire [30:0]          solar_first,
	input  wire [30:0]          solar_second,
	input  wire                 start_of_run,
	input  wire                 end_of_run,
	output logic [30:0]         energy_level,
	output logic signed [31:0]  applied_power,
	output logic                loss_flag,
	output logic [23:0]         loss_count,
	output logic [47:0]         deficit_total,
	output logic [47:0]         load_total,
	output logic                run_done
);
	import bes_pkg::*;

	localparam int unsigned RW = $clog2(BACKOFF_STEPS + 1);
	localparam logic [RW:0] NV = (RW + 1)'(BACKOFF_STEPS);
	localparam logic [RW-1:0] NR = RW'(BACKOFF_STEPS);
	// floor(p / N) = (p * RECIP) >> DSH for every 31-bit p
	localparam int unsigned DSH = 31 + $clog2(BACKOFF_STEPS);
	localparam logic [31:0] RECIP =
		32'(((64'd1 << DSH) + 64'(BACKOFF_STEPS - 1)) / 64'(BACKOFF_STEPS));
	localparam logic [47:0] MAX48 = '1;
	localparam logic [23:0] MAX24 = '1;

	logic [30:0]        ld_q, s0_q, s1_q, e_q, p_q, d_q, t_q, m_q, div_q;
	logic               eor_q, chg_q;
	logic [46:0]        sol_q;
	logic [RW-1:0]      rem_q, tr_q;
	logic signed [63:0] prod_q;
	logic signed [49:0] lim_q;
	logic [23:0]        cnt_q;
	logic [47:0]        def_q, ldt_q;

	logic signed [32:0] ma, mb;
	logic signed [47:0] psh;
	logic signed [49:0] b_val, e_new;
	logic [47:0]        sol_diff;
	logic [63:0]        quo_full;
	logic [RW-1:0]      rem_low;
	logic [RW:0]        tr_diff;
	logic               ok;
	logic [48:0]        ldt_sum, def_sum;

	assign psh = prod_q[63:16];

	// operand select for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (ctl.cmd)
			CMD_MUL_S0: begin
				ma = {2'b0, s0_q};
				mb = {2'b0, cfg.pv_gain_first};
			end
			CMD_MUL_S1: begin
				if (N_ROOFS > 1) begin
					ma = {2'b0, s1_q};
					mb = {2'b0, cfg.pv_gain_second};
				end
			end
			CMD_DIV: begin
				ma = {2'b0, p_q};
				mb = {1'b0, RECIP};
			end
			CMD_TRIAL_A: begin
				ma = chg_q ? 33'(cfg.charge_slope) : 33'(cfg.discharge_slope);
				mb = {2'b0, t_q};
			end
			CMD_TRIAL_B: begin
				ma = {2'b0, t_q};
				mb = {2'b0, chg_q ? cfg.charge_gain : cfg.discharge_gain};
			end
			CMD_APPLY: begin
				ma = {2'b0, (t_q > cfg.capacity) ? cfg.capacity : t_q};
				mb = {2'b0, chg_q ? cfg.charge_gain : cfg.discharge_gain};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		sol_diff = {1'b0, sol_q} - {17'b0, ld_q};
		quo_full = prod_q >> DSH;
		rem_low  = p_q[RW-1:0] - quo_full[RW-1:0] * NR;
		tr_diff  = {1'b0, tr_q} - {1'b0, rem_q};
		b_val    = chg_q ? ($signed({19'b0, e_q}) + 50'(psh))
		                 : ($signed({19'b0, e_q}) - 50'(psh));
		ok       = chg_q ? (b_val <= lim_q) : (b_val >= lim_q);
		e_new    = b_val;
		ldt_sum  = {1'b0, ldt_q} + {18'b0, load_sample};
		def_sum  = {1'b0, def_q} + {18'b0, d_q - m_q};
	end

	assign sts.trial_ok = ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q          <= '0;
			s0_q          <= '0;
			s1_q          <= '0;
			e_q           <= '0;
			p_q           <= '0;
			d_q           <= '0;
			t_q           <= '0;
			m_q           <= '0;
			div_q         <= '0;
			eor_q         <= 1'b0;
			chg_q         <= 1'b0;
			sol_q         <= '0;
			rem_q         <= '0;
			tr_q          <= '0;
			prod_q        <= '0;
			lim_q         <= '0;
			cnt_q         <= '0;
			def_q         <= '0;
			ldt_q         <= '0;
			energy_level  <= '0;
			applied_power <= '0;
			loss_flag     <= 1'b0;
			loss_count    <= '0;
			deficit_total <= '0;
			load_total    <= '0;
			run_done      <= 1'b0;
		end else begin
			if (ctl.cmd != CMD_NONE) begin
				prod_q <= 64'(ma * mb);
			end
			case (ctl.cmd)
				CMD_LOAD: begin
					ld_q  <= load_sample;
					s0_q  <= solar_first;
					s1_q  <= solar_second;
					eor_q <= end_of_run;
					if (start_of_run) begin
						e_q   <= cfg.initial_energy;
						cnt_q <= '0;
						def_q <= '0;
						ldt_q <= {17'b0, load_sample};
					end else begin
						ldt_q <= ldt_sum[48] ? MAX48 : ldt_sum[47:0];
					end
				end
				CMD_MUL_S1: sol_q <= psh[46:0];
				CMD_SUM:    sol_q <= sol_q + psh[46:0];
				CMD_DIR: begin
					chg_q <= sol_q > {16'b0, ld_q};
					if (sol_q > {16'b0, ld_q}) begin
						p_q <= (sol_diff > 48'h7FFF_FFFF) ? '1 : sol_diff[30:0];
						t_q <= (sol_diff > 48'h7FFF_FFFF) ? '1 : sol_diff[30:0];
						d_q <= '0;
					end else begin
						p_q <= ld_q - sol_q[30:0];
						t_q <= ld_q - sol_q[30:0];
						d_q <= ld_q - sol_q[30:0];
					end
				end
				CMD_QUO: begin
					div_q <= quo_full[30:0];
					rem_q <= rem_low;
					tr_q  <= '0;
				end
				CMD_TRIAL_B: lim_q <= 50'(psh) + (chg_q ? {19'b0, cfg.capacity} : 50'd0);
				CMD_TRIAL_C: begin
					// step t down by p/N, carrying the remainder
					if (!ok && !ctl.last) begin
						if (tr_diff[RW]) begin
							tr_q <= RW'(tr_diff + NV);
							t_q  <= t_q - div_q - 31'd1;
						end else begin
							tr_q <= tr_diff[RW-1:0];
							t_q  <= t_q - div_q;
						end
					end
				end
				CMD_APPLY: m_q <= (t_q > cfg.capacity) ? cfg.capacity : t_q;
				CMD_FIN: begin
					if (e_new < 0) begin
						e_q          <= '0;
						energy_level <= '0;
					end else if (e_new > 50'sh7FFF_FFFF) begin
						e_q          <= '1;
						energy_level <= '1;
					end else begin
						e_q          <= e_new[30:0];
						energy_level <= e_new[30:0];
					end
					applied_power <= chg_q ? $signed({1'b0, m_q}) : -$signed({1'b0, m_q});
					loss_flag     <= !chg_q && (m_q < d_q);
					run_done      <= eor_q;
					load_total    <= ldt_q;
					if (!chg_q && (m_q < d_q)) begin
						cnt_q         <= (cnt_q == MAX24) ? cnt_q : cnt_q + 24'd1;
						loss_count    <= (cnt_q == MAX24) ? cnt_q : cnt_q + 24'd1;
						def_q         <= def_sum[48] ? MAX48 : def_sum[47:0];
						deficit_total <= def_sum[48] ? MAX48 : def_sum[47:0];
					end else begin
						loss_count    <= cnt_q;
						deficit_total <= def_q;
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/bes_ctrl.sv
// ----------------------------------------------------------------------------
// bes_ctrl
// Sequencer of the battery step simulator: orders the multiplies, the
// divide and the back-off trials, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module bes_ctrl #(
	parameter int unsigned BACKOFF_STEPS = 30
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	output bes_pkg::ctl_t      ctl,
	input  wire bes_pkg::sts_t sts
);
	import bes_pkg::*;
	`include "battery_energy_step_sim_top_assert.svh"

	localparam int unsigned KW = $clog2(BACKOFF_STEPS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL0, ST_MUL1, ST_SUM, ST_DIR, ST_DIV, ST_QUO,
		ST_TA, ST_TB, ST_TC, ST_APPLY, ST_FIN
	} state_t;

	state_t        state_q;
	logic [KW-1:0] k_q;
	logic          fin_go;

	assign in_ready = (state_q == ST_IDLE);
	assign fin_go   = !out_valid || out_ready;

	always_comb begin
		ctl.last = (k_q == KW'(BACKOFF_STEPS));
		case (state_q)
			ST_IDLE:  ctl.cmd = in_valid ? CMD_LOAD : CMD_NONE;
			ST_MUL0:  ctl.cmd = CMD_MUL_S0;
			ST_MUL1:  ctl.cmd = CMD_MUL_S1;
			ST_SUM:   ctl.cmd = CMD_SUM;
			ST_DIR:   ctl.cmd = CMD_DIR;
			ST_DIV:   ctl.cmd = CMD_DIV;
			ST_QUO:   ctl.cmd = CMD_QUO;
			ST_TA:    ctl.cmd = CMD_TRIAL_A;
			ST_TB:    ctl.cmd = CMD_TRIAL_B;
			ST_TC:    ctl.cmd = CMD_TRIAL_C;
			ST_APPLY: ctl.cmd = CMD_APPLY;
			ST_FIN:   ctl.cmd = fin_go ? CMD_FIN : CMD_NONE;
			default:  ctl.cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_FIN && fin_go) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_MUL0;
				ST_MUL0:  state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_DIR;
				ST_DIR:   state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_QUO;
				ST_QUO: begin
					k_q     <= '0;
					state_q <= ST_TA;
				end
				ST_TA:    state_q <= ST_TB;
				ST_TB:    state_q <= ST_TC;
				ST_TC: begin
					if (sts.trial_ok || ctl.last) begin
						state_q <= ST_APPLY;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_TA;
					end
				end
				ST_APPLY: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	`BES_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted while busy")
	`BES_ASSERT(a_no_overwrite, (state_q == ST_FIN && out_valid && !out_ready) |=> (state_q == ST_FIN), "result overwritten")
	`BES_ASSERT(a_trial_bound, k_q <= KW'(BACKOFF_STEPS), "trial count past limit")
	`BES_ASSERT(a_ready_idle_only, in_ready |-> (state_q == ST_IDLE), "ready outside idle")
endmodule
`default_nettype wire

>>> bench/tb_battery_energy_step_sim_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_battery_energy_step_sim_top
// Self-checking bench for the battery energy step simulator.
// ----------------------------------------------------------------------------
// A behavioral copy of the step arithmetic predicts every result transaction.
// Results are checked in order, field by field. Directed steps hit the field
// extremes and the saturation corners. Random runs follow, framed with
// start_of_run and end_of_run, under several register settings. Random gaps
// are placed on both streams.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_battery_energy_step_sim_top;
	import bes_pkg::*;

	localparam int       BACKOFF = 30;
	localparam longint   MAX31   = 64'h7FFF_FFFF;
	localparam longint   MAX24   = 64'hFF_FFFF;
	localparam longint   MAX48   = 64'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [30:0] energy_level;
		logic [31:0] applied_power;
		logic        loss_flag;
		logic [23:0] loss_count;
		logic [47:0] deficit_total;
		logic [47:0] load_total;
		logic        run_done;
	} step_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [183:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_wdata = '0;

	battery_energy_step_sim_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// Predictor state: registers and the battery/totals mirror.
	cfg_t         battery_cfg;
	longint       stored_energy;
	longint       loss_tally;
	longint       deficit_sum;
	longint       load_accum;
	step_result_t expected_steps[$];
	int           mismatch_count = 0;
	bit           gaps_enabled = 1'b1;

	initial begin
		forever #6 clk = ~clk;
	end

	// Draw an idle gap for one transaction; zero during back-to-back phases.
	function automatic int draw_gap();
		return gaps_enabled ? $urandom_range(0, 19) : 0;
	endfunction

	// Floor of a Q16.16 product, both operands signed 64-bit.
	function automatic longint q_mul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	// Walk the back-off trials and return the first power meeting the limit.
	function automatic longint backed_off_power(longint req, bit charging);
		longint trial;
		longint limit;
		longint level;
		for (int k = 0; k <= BACKOFF; k++) begin
			trial = req * (BACKOFF - k) / BACKOFF;
			if (charging) begin
				limit = q_mul(longint'(battery_cfg.charge_slope), trial)
					+ longint'(battery_cfg.capacity);
				level = stored_energy + q_mul(trial, longint'(battery_cfg.charge_gain));
				if (level <= limit)
					return trial;
			end else begin
				limit = q_mul(longint'(battery_cfg.discharge_slope), trial);
				level = stored_energy - q_mul(trial, longint'(battery_cfg.discharge_gain));
				if (level >= limit)
					return trial;
			end
		end
		return 0;
	endfunction

	// Advance the battery mirror by one time step and return what it reports.
	function automatic step_result_t predict_step(logic [30:0] load_in, logic [30:0] sun_a,
		logic [30:0] sun_b, logic sor, logic eor);
		step_result_t r;
		longint solar;
		longint load;
		longint req;
		longint pwr;
		load = longint'(load_in);
		r    = '0;
		if (sor) begin
			stored_energy = longint'(battery_cfg.initial_energy);
			loss_tally    = 0;
			deficit_sum   = 0;
			load_accum    = 0;
		end
		solar = q_mul(longint'(sun_a), longint'(battery_cfg.pv_gain_first))
			+ q_mul(longint'(sun_b), longint'(battery_cfg.pv_gain_second));
		load_accum = (load_accum + load > MAX48) ? MAX48 : load_accum + load;
		if (solar > load) begin
			req = solar - load;
			if (req > MAX31)
				req = MAX31;
			pwr = backed_off_power(req, 1'b1);
			if (pwr > longint'(battery_cfg.capacity))
				pwr = longint'(battery_cfg.capacity);
			stored_energy += q_mul(pwr, longint'(battery_cfg.charge_gain));
			r.applied_power = pwr[31:0];
		end else begin
			req = load - solar;
			pwr = backed_off_power(req, 1'b0);
			if (pwr > longint'(battery_cfg.capacity))
				pwr = longint'(battery_cfg.capacity);
			stored_energy -= q_mul(pwr, longint'(battery_cfg.discharge_gain));
			r.applied_power = 32'(-pwr);
			if (pwr < req) begin
				r.loss_flag = 1'b1;
				loss_tally  = (loss_tally + 1 > MAX24) ? MAX24 : loss_tally + 1;
				deficit_sum = (deficit_sum + req - pwr > MAX48) ? MAX48
					: deficit_sum + req - pwr;
			end
		end
		if (stored_energy < 0)
			stored_energy = 0;
		if (stored_energy > MAX31)
			stored_energy = MAX31;
		r.energy_level  = stored_energy[30:0];
		r.loss_count    = loss_tally[23:0];
		r.deficit_total = deficit_sum[47:0];
		r.load_total    = load_accum[47:0];
		r.run_done      = eor;
		return r;
	endfunction

	// Send one time step; valid stays high after acceptance for a gapless next step.
	task automatic send_step(logic [30:0] load_in, logic [30:0] sun_a, logic [30:0] sun_b,
		logic sor, logic eor);
		int           gap;
		step_result_t next_r;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, sun_b, sun_a, load_in};
		s_axis_tuser  <= sor;
		s_axis_tlast  <= eor;
		do @(posedge clk); while (!s_axis_tready);
		next_r = predict_step(load_in, sun_a, sun_b, sor, eor);
		expected_steps.insert(expected_steps.size(), next_r);
	endtask

	// Drop valid and hold until every predicted result has been taken.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_steps.size() != 0)
			@(posedge clk);
	endtask

	// Write all eight registers, mirroring each into the predictor.
	task automatic load_config(cfg_t c);
		logic [31:0] vals[8];
		vals[CFG_CAPACITY]        = {1'b0, c.capacity};
		vals[CFG_INITIAL_ENERGY]  = {1'b0, c.initial_energy};
		vals[CFG_CHARGE_SLOPE]    = c.charge_slope;
		vals[CFG_DISCHARGE_SLOPE] = c.discharge_slope;
		vals[CFG_CHARGE_GAIN]     = {1'b0, c.charge_gain};
		vals[CFG_DISCHARGE_GAIN]  = {1'b0, c.discharge_gain};
		vals[CFG_PV_GAIN_FIRST]   = {1'b0, c.pv_gain_first};
		vals[CFG_PV_GAIN_SECOND]  = {1'b0, c.pv_gain_second};
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		battery_cfg = c;
	endtask

	// Pick a register value: mostly moderate, sometimes an extreme.
	function automatic logic [30:0] pick_u31(int unsigned moderate_max);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom);
			default: return 31'($urandom_range(0, moderate_max));
		endcase
	endfunction

	function automatic logic [31:0] pick_slope();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			3: return '0;
			default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
		endcase
	endfunction

	// Sample values: mostly at the battery's scale, sometimes full range.
	function automatic logic [30:0] pick_sample();
		return ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
	endfunction

	task automatic test_reset_defaults();
		// Reset values: no solar weight, zero capacity; every nonzero load is a loss.
		send_step(31'd0, 31'd0, 31'd0, 1'b0, 1'b0);
		send_step(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b1);
		send_step(31'd65536, 31'd0, 31'd0, 1'b1, 1'b0);
		wait_idle();
	endtask

	task automatic test_directed_corners();
		cfg_t c;
		// Full gains and capacity: the charge request saturates, a full discharge clamps the energy at zero.
		c = '{capacity: 31'h7FFF_FFFF, initial_energy: 31'h7FFF_0000,
			charge_slope: 32'sh0000_0000, discharge_slope: 32'sh8000_0000,
			charge_gain: 31'h7FFF_FFFF, discharge_gain: 31'h7FFF_FFFF,
			pv_gain_first: 31'h7FFF_FFFF, pv_gain_second: 31'h7FFF_FFFF};
		load_config(c);
		send_step(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0);
		send_step(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 1'b0, 1'b0);
		send_step(31'h7FFF_FFFF, 31'd0, 31'd0, 1'b0, 1'b0);
		send_step(31'h7FFF_FFFF, 31'd0, 31'd0, 1'b0, 1'b1);
		wait_idle();
		// Unit gains: a tie discharges nothing, deficits are backed off and flagged as losses.
		c = '{capacity: 31'd655360, initial_energy: 31'd131072,
			charge_slope: 32'sh7FFF_FFFF, discharge_slope: 32'sh0001_0000,
			charge_gain: 31'd65536, discharge_gain: 31'd65536,
			pv_gain_first: 31'd65536, pv_gain_second: 31'd0};
		load_config(c);
		send_step(31'd65536, 31'd65536, 31'h7FFF_FFFF, 1'b1, 1'b0);
		send_step(31'd300000, 31'd0, 31'd0, 1'b0, 1'b0);
		send_step(31'd300000, 31'd0, 31'd0, 1'b0, 1'b0);
		send_step(31'd0, 31'd200000, 31'd0, 1'b0, 1'b0);
		send_step(31'd1, 31'd0, 31'd0, 1'b0, 1'b1);
		// State carries on past end_of_run until the next start.
		send_step(31'd50000, 31'd0, 31'd0, 1'b0, 1'b0);
		wait_idle();
		// A negative charge slope and a large positive discharge slope force every back-off trial to run.
		c.charge_slope    = 32'sh8000_0000;
		c.discharge_slope = 32'sh7FFF_FFFF;
		c.pv_gain_second  = 31'd32768;
		load_config(c);
		send_step(31'd0, 31'd400000, 31'd400000, 1'b1, 1'b0);
		send_step(31'd400000, 31'd0, 31'd0, 1'b0, 1'b0);
		send_step(31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0, 1'b1);
		wait_idle();
	endtask

	// Random framed runs under one random register setting, with some noise steps.
	task automatic test_random_runs(int steps);
		cfg_t c;
		int   run_left;
		logic sor;
		logic eor;
		c.capacity        = pick_u31(1 << 24);
		c.initial_energy  = pick_u31(1 << 24);
		c.charge_slope    = pick_slope();
		c.discharge_slope = pick_slope();
		c.charge_gain     = pick_u31(1 << 18);
		c.discharge_gain  = pick_u31(1 << 18);
		c.pv_gain_first   = pick_u31(1 << 18);
		c.pv_gain_second  = pick_u31(1 << 18);
		load_config(c);
		run_left = 0;
		for (int i = 0; i < steps; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				// Noise: flags at random regardless of framing.
				sor = 1'($urandom);
				eor = 1'($urandom);
			end else begin
				sor = (run_left == 0);
				if (run_left == 0)
					run_left = $urandom_range(1, 30);
				run_left--;
				eor = (run_left == 0);
			end
			send_step(pick_sample(), pick_sample(), pick_sample(), sor, eor);
		end
		wait_idle();
	endtask

	// Check each result transaction against the oldest prediction.
	initial begin
		int           stall;
		step_result_t exp_r;
		step_result_t got;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.energy_level  = m_axis_tdata[30:0];
			got.applied_power = m_axis_tdata[62:31];
			got.loss_count    = m_axis_tdata[86:63];
			got.deficit_total = m_axis_tdata[134:87];
			got.load_total    = m_axis_tdata[182:135];
			got.loss_flag     = m_axis_tuser;
			got.run_done      = m_axis_tlast;
			if (expected_steps.size() == 0) begin
				$error("unexpected result transaction: energy_level %0d", got.energy_level);
				mismatch_count++;
			end else begin
				exp_r = expected_steps[0];
				expected_steps.delete(0);
				if (got.energy_level !== exp_r.energy_level) begin
					$error("energy_level: expected %0d, got %0d",
						exp_r.energy_level, got.energy_level);
					mismatch_count++;
				end
				if (got.applied_power !== exp_r.applied_power) begin
					$error("applied_power: expected %0d, got %0d",
						$signed(exp_r.applied_power), $signed(got.applied_power));
					mismatch_count++;
				end
				if (got.loss_flag !== exp_r.loss_flag) begin
					$error("loss_flag: expected %0b, got %0b", exp_r.loss_flag, got.loss_flag);
					mismatch_count++;
				end
				if (got.loss_count !== exp_r.loss_count) begin
					$error("loss_count: expected %0d, got %0d", exp_r.loss_count, got.loss_count);
					mismatch_count++;
				end
				if (got.deficit_total !== exp_r.deficit_total) begin
					$error("deficit_total: expected %0d, got %0d",
						exp_r.deficit_total, got.deficit_total);
					mismatch_count++;
				end
				if (got.load_total !== exp_r.load_total) begin
					$error("load_total: expected %0d, got %0d", exp_r.load_total, got.load_total);
					mismatch_count++;
				end
				if (got.run_done !== exp_r.run_done) begin
					$error("run_done: expected %0b, got %0b", exp_r.run_done, got.run_done);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence: reset once, then each test in turn.
	initial begin
		battery_cfg = '{capacity: 31'd0, initial_energy: 31'd0, charge_slope: 32'sd0,
			discharge_slope: 32'sd0, charge_gain: 31'd65536, discharge_gain: 31'd65536,
			pv_gain_first: 31'd0, pv_gain_second: 31'd0};
		stored_energy = 0;
		loss_tally    = 0;
		deficit_sum   = 0;
		load_accum    = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_corners();
		for (int p = 0; p < 5; p++) begin
			// One phase runs with no gaps on either stream.
			gaps_enabled = (p != 2);
			test_random_runs(185);
		end
		gaps_enabled = 1'b1;
		repeat (140) @(posedge clk);
		if (mismatch_count == 0 && expected_steps.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
+incdir+design
design/bes_pkg.sv
design/bes_datapath.sv
design/bes_ctrl.sv
design/battery_energy_step_sim_top.sv
bench/tb_battery_energy_step_sim_top.sv
